@@ rtl/btb_pkg.sv @@
`timescale 1ns / 1ps

package btb_pkg;

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 4;
  localparam int CTR_W  = 2;
  localparam int PEN_W  = 8;

  localparam logic [CTR_W-1:0] CTR_WEAK_NOT_TAKEN = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX            = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN            = 2'd0;
  localparam logic [PEN_W-1:0] PENALTY_RESET      = 8'd14;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PEN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MISS_PENALTY       = 1'd0,
    REG_MISPREDICT_PENALTY = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } btb_state_t;

  typedef struct packed {
    logic              is_branch;
    logic              is_conditional;
    logic [ADDR_W-1:0] instr_addr;
    logic [SIZE_W-1:0] instr_size;
    logic [ADDR_W-1:0] following_addr;
  } btb_req_t;

  typedef struct packed {
    logic             buffer_hit;
    logic             predicted_valid;
    logic             predicted_taken;
    logic             actual_taken;
    logic             mispredicted;
    logic [PEN_W-1:0] stall_cycles;
  } btb_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic commit;
  } btb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } btb_sts_t;

endpackage

@@ rtl/btb_ram.sv @@
`timescale 1ns / 1ps

module btb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/btb_ctrl.sv @@
`timescale 1ns / 1ps

module btb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  btb_pkg::btb_sts_t sts,
  output btb_pkg::btb_cmd_t cmd
);

  btb_pkg::btb_state_t state_r;
  btb_pkg::btb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btb_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = btb_pkg::ST_IDLE;
      end
      btb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = btb_pkg::ST_LOOKUP;
      end
      btb_pkg::ST_LOOKUP: begin
        if (sts.out_free) state_nxt = btb_pkg::ST_IDLE;
      end
      default: state_nxt = btb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.clr_step = 1'b0;
    cmd.capture  = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      btb_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      btb_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      btb_pkg::ST_LOOKUP: begin
        // hold the set row until the result register can take the result
        cmd.commit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/btb_dpath.sv @@
`timescale 1ns / 1ps

module btb_dpath #(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btb_pkg::btb_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output btb_pkg::btb_rsp_t                   out_data,
  input  logic                                cfg_we,
  input  logic [btb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [btb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  btb_pkg::btb_cmd_t                   cmd,
  output btb_pkg::btb_sts_t                   sts
);

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_IW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = btb_pkg::ADDR_W;
  localparam int CTR_W  = btb_pkg::CTR_W;
  // per way: {tag, valid, counter, age}
  localparam int WAY_W  = TAG_W + 1 + CTR_W + WAY_IW;
  localparam int ROW_W  = NUM_WAYS * WAY_W;
  localparam logic [WAY_IW-1:0] AGE_OLDEST = WAY_IW'(NUM_WAYS - 1);

  // configuration
  logic [btb_pkg::PEN_W-1:0] miss_pen_r;
  logic [btb_pkg::PEN_W-1:0] misp_pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_pen_r <= btb_pkg::PENALTY_RESET;
      misp_pen_r <= btb_pkg::PENALTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        btb_pkg::REG_MISS_PENALTY:       miss_pen_r <= cfg_wdata;
        btb_pkg::REG_MISPREDICT_PENALTY: misp_pen_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clearing pass address
  logic [SET_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr_r == SET_W'(NUM_SETS - 1));

  // request register
  btb_pkg::btb_req_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  // set row storage
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] clr_row;

  btb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_data.instr_addr[SET_W-1:0]),
    .rdata (rd_row)
  );

  assign ram_we    = cmd.clr_step | (cmd.commit & req_r.is_branch);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : req_r.instr_addr[SET_W-1:0];
  assign ram_wdata = cmd.clr_step ? clr_row : upd_row;

  // lookup and update
  logic [TAG_W-1:0]  tag   [NUM_WAYS];
  logic              vld   [NUM_WAYS];
  logic [CTR_W-1:0]  ctr   [NUM_WAYS];
  logic [WAY_IW-1:0] age   [NUM_WAYS];
  logic [WAY_IW-1:0] age_n [NUM_WAYS];
  logic              hit;
  logic [WAY_IW-1:0] hit_way;
  logic              inv_found;
  logic [WAY_IW-1:0] inv_way;
  logic [WAY_IW-1:0] old_way;
  logic [WAY_IW-1:0] sel_way;
  logic [WAY_IW-1:0] sel_age;
  logic [CTR_W-1:0]  hit_ctr;
  logic [CTR_W-1:0]  ctr_n;
  logic [TAG_W-1:0]  fall_addr;
  logic              pred_taken;
  logic              act_taken;
  btb_pkg::btb_rsp_t rsp;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      age[w] = rd_row[w*WAY_W +: WAY_IW];
      ctr[w] = rd_row[w*WAY_W + WAY_IW +: CTR_W];
      vld[w] = rd_row[w*WAY_W + WAY_IW + CTR_W];
      tag[w] = rd_row[w*WAY_W + WAY_IW + CTR_W + 1 +: TAG_W];
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    old_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && vld[w] && (tag[w] == req_r.instr_addr)) begin
        hit     = 1'b1;
        hit_way = WAY_IW'(w);
      end
      if (!inv_found && !vld[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_IW'(w);
      end
      // ages stay a permutation, so exactly one way is the oldest
      if (age[w] == AGE_OLDEST) begin
        old_way = WAY_IW'(w);
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = old_way;
    end
    sel_age = age[sel_way];
    hit_ctr = ctr[hit_way];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_IW'(w) == sel_way) begin
        age_n[w] = '0;
      end else if (age[w] < sel_age) begin
        age_n[w] = age[w] + 1'b1;
      end else begin
        age_n[w] = age[w];
      end
    end
  end

  assign fall_addr  = req_r.instr_addr + {{(TAG_W - btb_pkg::SIZE_W){1'b0}}, req_r.instr_size};
  assign act_taken  = (req_r.following_addr != fall_addr);
  assign pred_taken = (hit_ctr < btb_pkg::CTR_WEAK_NOT_TAKEN);

  always_comb begin
    // taken moves toward strongly taken (zero)
    if (act_taken) begin
      ctr_n = (hit_ctr != btb_pkg::CTR_MIN) ? hit_ctr - 1'b1 : hit_ctr;
    end else begin
      ctr_n = (hit_ctr != btb_pkg::CTR_MAX) ? hit_ctr + 1'b1 : hit_ctr;
    end
  end

  always_comb begin
    upd_row = rd_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      upd_row[w*WAY_W +: WAY_IW] = age_n[w];
      if (WAY_IW'(w) == sel_way) begin
        if (hit) begin
          if (req_r.is_conditional) begin
            upd_row[w*WAY_W + WAY_IW +: CTR_W] = ctr_n;
          end
        end else begin
          // refill keeps the old counter
          upd_row[w*WAY_W + WAY_IW + CTR_W]              = 1'b1;
          upd_row[w*WAY_W + WAY_IW + CTR_W + 1 +: TAG_W] = req_r.instr_addr;
        end
      end
    end
  end

  always_comb begin
    clr_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      clr_row[w*WAY_W +: WAY_IW] = WAY_IW'(w);
    end
  end

  always_comb begin
    rsp = '0;
    if (req_r.is_branch) begin
      if (hit) begin
        rsp.buffer_hit = 1'b1;
        if (req_r.is_conditional) begin
          rsp.predicted_valid = 1'b1;
          rsp.predicted_taken = pred_taken;
          rsp.actual_taken    = act_taken;
          rsp.mispredicted    = pred_taken ^ act_taken;
          rsp.stall_cycles    = (pred_taken ^ act_taken) ? misp_pen_r : '0;
        end
      end else begin
        rsp.stall_cycles = miss_pen_r;
      end
    end
  end

  // result register
  logic              out_valid_r;
  btb_pkg::btb_rsp_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= rsp;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

@@ rtl/btb_two_bit_branch_predictor.sv @@
`timescale 1ns / 1ps
// An accepted request is registered and its set row read from the buffer RAM;
// the row is then compared, written back for a branch, and the result registered,
// which waits while the result register is full. No new request is taken meanwhile.
// Reset: synchronous; afterwards a clearing pass writes every set row (NUM_SETS,
// 1024 by default) with in_stall high. Penalties reset to 14.
module btb_two_bit_branch_predictor #(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  btb_pkg::btb_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output btb_pkg::btb_rsp_t              out_data,
  input  logic                           cfg_we,
  input  logic [btb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [btb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  btb_pkg::btb_cmd_t cmd;
  btb_pkg::btb_sts_t sts;

  btb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  btb_dpath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ tb/btb_outcome_checker.sv @@
`timescale 1ns / 1ps

module btb_outcome_checker #(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  btb_pkg::btb_req_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  btb_pkg::btb_rsp_t              out_data,
  input  logic                           cfg_we,
  input  logic [btb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [btb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatch_count,
  output int                             outcomes_due
);
  import btb_pkg::*;

  localparam int MAX_PRINTED = 40;

  logic [ADDR_W-1:0] tag_mem   [NUM_SETS][NUM_WAYS];
  bit                way_valid [NUM_SETS][NUM_WAYS];
  logic [CTR_W-1:0]  dir_ctr   [NUM_SETS][NUM_WAYS];
  int unsigned       lru_age   [NUM_SETS][NUM_WAYS];
  logic [PEN_W-1:0]  miss_pen;
  logic [PEN_W-1:0]  mispred_pen;
  btb_rsp_t          expected_outcomes [$];

  initial begin
    mismatch_count = 0;
    outcomes_due   = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Age 0 is the most recent way; ages younger than the touched way move back by one.
  function automatic void touch_way(int set_idx, int way);
    int unsigned prev;
    prev = lru_age[set_idx][way];
    for (int v = 0; v < NUM_WAYS; v++)
      if (lru_age[set_idx][v] < prev)
        lru_age[set_idx][v]++;
    lru_age[set_idx][way] = 0;
  endfunction

  function automatic btb_rsp_t predict_outcome(btb_req_t req);
    btb_rsp_t          rsp;
    int                set_idx;
    int                way;
    int unsigned       oldest;
    logic [ADDR_W-1:0] fall_through;
    logic [CTR_W-1:0]  ctr;
    rsp = '0;
    if (!req.is_branch)
      return rsp;
    set_idx = int'(req.instr_addr % 64'(NUM_SETS));
    way = -1;
    for (int w = 0; w < NUM_WAYS; w++)
      if (way < 0 && way_valid[set_idx][w] && tag_mem[set_idx][w] == req.instr_addr)
        way = w;
    if (way < 0) begin
      // fill invalid ways first, else evict the oldest; the counter stays
      for (int w = 0; w < NUM_WAYS; w++)
        if (way < 0 && !way_valid[set_idx][w])
          way = w;
      if (way < 0) begin
        oldest = 0;
        way = 0;
        for (int w = 0; w < NUM_WAYS; w++)
          if (lru_age[set_idx][w] >= oldest) begin
            oldest = lru_age[set_idx][w];
            way = w;
          end
      end
      tag_mem[set_idx][way]   = req.instr_addr;
      way_valid[set_idx][way] = 1'b1;
      touch_way(set_idx, way);
      rsp.stall_cycles = miss_pen;
    end else begin
      rsp.buffer_hit = 1'b1;
      touch_way(set_idx, way);
      if (req.is_conditional) begin
        ctr = dir_ctr[set_idx][way];
        fall_through = req.instr_addr + ADDR_W'(req.instr_size);
        rsp.predicted_valid = 1'b1;
        rsp.predicted_taken = (ctr < CTR_WEAK_NOT_TAKEN);
        rsp.actual_taken    = (req.following_addr != fall_through);
        rsp.mispredicted    = (rsp.predicted_taken != rsp.actual_taken);
        if (rsp.mispredicted)
          rsp.stall_cycles = mispred_pen;
        if (rsp.actual_taken) begin
          if (ctr != CTR_MIN)
            ctr--;
        end else if (ctr != CTR_MAX) begin
          ctr++;
        end
        dir_ctr[set_idx][way] = ctr;
      end
    end
    return rsp;
  endfunction

  task automatic compare_outcome(btb_rsp_t got, btb_rsp_t want);
    if (got.buffer_hit !== want.buffer_hit)
      report_mismatch("buffer_hit", 64'(got.buffer_hit), 64'(want.buffer_hit));
    if (got.predicted_valid !== want.predicted_valid)
      report_mismatch("predicted_valid", 64'(got.predicted_valid), 64'(want.predicted_valid));
    if (got.predicted_taken !== want.predicted_taken)
      report_mismatch("predicted_taken", 64'(got.predicted_taken), 64'(want.predicted_taken));
    if (got.actual_taken !== want.actual_taken)
      report_mismatch("actual_taken", 64'(got.actual_taken), 64'(want.actual_taken));
    if (got.mispredicted !== want.mispredicted)
      report_mismatch("mispredicted", 64'(got.mispredicted), 64'(want.mispredicted));
    if (got.stall_cycles !== want.stall_cycles)
      report_mismatch("stall_cycles", 64'(got.stall_cycles), 64'(want.stall_cycles));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) begin
          way_valid[s][w] = 1'b0;
          dir_ctr[s][w]   = CTR_MIN;
          lru_age[s][w]   = w;
        end
      miss_pen    = PENALTY_RESET;
      mispred_pen = PENALTY_RESET;
      expected_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_MISS_PENALTY:       miss_pen = cfg_wdata;
          REG_MISPREDICT_PENALTY: mispred_pen = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_outcomes.push_back(predict_outcome(in_data));
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0)
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        else
          compare_outcome(out_data, expected_outcomes.pop_front());
      end
    end
    outcomes_due = expected_outcomes.size();
  end

endmodule

@@ tb/tb_btb_two_bit_branch_predictor.sv @@
`timescale 1ns / 1ps

module tb_btb_two_bit_branch_predictor;
  import btb_pkg::*;

  localparam int HOT_COUNT     = 24;
  localparam int SET_BITS      = 10;
  localparam int BRANCHES_EACH = 250;
  localparam int LONG_HOLD     = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  btb_req_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  btb_rsp_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatch_count;
  int                    outcomes_due;

  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    hold_requests = 0;
  int                    hold_served = 0;
  int                    hold_left = 0;
  logic [ADDR_W-1:0]     hot_addr [HOT_COUNT];
  int                    taken_bias [HOT_COUNT];

  btb_two_bit_branch_predictor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  btb_outcome_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outcomes_due   (outcomes_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic btb_req_t mk_req(logic br, logic cond, logic [ADDR_W-1:0] addr,
                                      logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] nxt);
    btb_req_t req;
    req.is_branch      = br;
    req.is_conditional = cond;
    req.instr_addr     = addr;
    req.instr_size     = size;
    req.following_addr = nxt;
    return req;
  endfunction

  // Mostly hot branches crowding a few sets, with per-branch taken bias.
  function automatic btb_req_t random_req();
    btb_req_t          req;
    int                sel;
    int                k;
    logic              taken;
    logic [ADDR_W-1:0] fall_through;
    req.is_branch      = ($urandom_range(99) < 88);
    req.is_conditional = ($urandom_range(99) < 70);
    req.instr_size     = SIZE_W'($urandom_range(15));
    sel = $urandom_range(99);
    if (sel < 75) begin
      k = $urandom_range(HOT_COUNT - 1);
      req.instr_addr = hot_addr[k];
      taken = ($urandom_range(99) < taken_bias[k]);
    end else begin
      req.instr_addr = {$urandom, $urandom};
      if (sel >= 96)
        req.instr_addr = '1 - ADDR_W'($urandom_range(15));
      taken = 1'($urandom_range(1));
    end
    fall_through = req.instr_addr + ADDR_W'(req.instr_size);
    if (!taken)
      req.following_addr = fall_through;
    else if ($urandom_range(3) == 0)
      req.following_addr = req.instr_addr;
    else
      req.following_addr = {$urandom, $urandom};
    return req;
  endfunction

  task automatic send_request(btb_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_due != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_penalties(logic [PEN_W-1:0] miss, logic [PEN_W-1:0] mispred);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MISS_PENALTY;
    cfg_wdata <= miss;
    @(posedge clk);
    cfg_idx   <= REG_MISPREDICT_PENALTY;
    cfg_wdata <= mispred;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int send_pct, int recv_pct, logic long_hold);
    btb_req_t req;
    int       branches;
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
    if (long_hold)
      hold_requests <= hold_requests + 1;
    branches = 0;
    while (branches < BRANCHES_EACH) begin
      req = random_req();
      send_request(req);
      if (req.is_branch)
        branches++;
    end
    wait_drained();
  endtask

  initial begin
    logic [SET_BITS-1:0] hot_set [4];
    logic [ADDR_W-1:0]   all_ones;
    all_ones = '1;
    hot_set[0] = '0;
    hot_set[1] = '1;
    hot_set[2] = SET_BITS'($urandom_range(1, 511));
    hot_set[3] = SET_BITS'($urandom_range(512, 1022));
    for (int k = 0; k < HOT_COUNT; k++) begin
      hot_addr[k] = {$urandom, $urandom};
      hot_addr[k][SET_BITS-1:0] = hot_set[k % 4];
      case (k % 5)
        0: taken_bias[k] = 90;
        1: taken_bias[k] = 10;
        2: taken_bias[k] = 50;
        3: taken_bias[k] = 97;
        default: taken_bias[k] = 3;
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the clearing pass is done
    do @(posedge clk); while (in_stall !== 1'b0);

    // directed part, reset penalties
    send_request(mk_req(1'b0, 1'b1, all_ones, 4'd15, all_ones));
    send_request(mk_req(1'b0, 1'b0, '0, 4'd0, '0));
    send_request(mk_req(1'b1, 1'b0, '0, 4'd4, '0));
    send_request(mk_req(1'b1, 1'b0, '0, 4'd4, 64'd100));
    send_request(mk_req(1'b1, 1'b1, '0, 4'd4, 64'h40));
    repeat (3) send_request(mk_req(1'b1, 1'b1, '0, 4'd4, 64'd4));
    send_request(mk_req(1'b1, 1'b1, '0, 4'd4, 64'd4));
    send_request(mk_req(1'b1, 1'b1, '0, 4'd4, 64'h80));
    // address plus size wraps around to 14
    send_request(mk_req(1'b1, 1'b1, all_ones, 4'd15, 64'd14));
    send_request(mk_req(1'b1, 1'b1, all_ones, 4'd15, 64'd14));
    send_request(mk_req(1'b1, 1'b1, all_ones, 4'd15, all_ones));
    // five tags into one set: the oldest gets evicted, then re-fetched
    for (int k = 1; k <= 5; k++)
      send_request(mk_req(1'b1, 1'b1, {54'(k), 10'd5}, 4'd2, {54'(k), 10'd7}));
    send_request(mk_req(1'b1, 1'b1, {54'd1, 10'd5}, 4'd2, {54'd1, 10'd7}));
    send_request(mk_req(1'b1, 1'b0, {54'd2, 10'd5}, 4'd2, '0));
    send_request(mk_req(1'b1, 1'b1, {54'd5, 10'd5}, 4'd2, {54'd5, 10'd7}));
    send_request(mk_req(1'b1, 1'b1, {54'd1, 10'd5}, 4'd2, {54'd1, 10'd7}));
    wait_drained();

    set_penalties(8'd0, 8'd255);
    run_random(0, 0, 1'b0);
    set_penalties(8'd255, 8'd0);
    run_random(59, 0, 1'b0);
    set_penalties(8'd1, 8'd128);
    run_random(0, 59, 1'b1);
    set_penalties(PEN_W'($urandom), PEN_W'($urandom));
    run_random(10, 10, 1'b0);
    set_penalties(8'd255, 8'd255);
    run_random(0, 0, 1'b0);

    if (mismatch_count == 0 && outcomes_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
